// ----- rtl/assert_macros.svh -----
// concurrent assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define FBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define FBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/fba_pkg.sv -----
// types, constants and microcode rom of the frame bitmap allocator
`timescale 1ns / 1ps
package fba_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned FRAME_SHIFT    = 12;
  localparam int unsigned FRAME_W        = 12;
  localparam int unsigned CFG_W          = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
  localparam int unsigned IN_TDATA_W     = 56;
  localparam int unsigned OUT_FIELDS_W   = 18;
  localparam int unsigned OUT_TDATA_W    = 24;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_TEST  = 3'd2,
    OP_MARK  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    U_WIPE,
    U_IDLE,
    U_DECODE,
    U_SCAN_RD,
    U_SCAN_CHK,
    U_TEST_RD,
    U_TEST_CAP,
    U_MARK_RD,
    U_MARK_WR,
    U_FREE_RD,
    U_FREE_WR,
    U_RESULT
  } upc_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_WIPE,
    ACT_LATCH,
    ACT_DECODE,
    ACT_SCAN_START,
    ACT_SCAN,
    ACT_READ_IDX,
    ACT_TEST,
    ACT_SET,
    ACT_CLR,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_WIPE_DONE,
    COND_IN_BEAT,
    COND_DISPATCH,
    COND_SCAN_END,
    COND_OUT_FREE
  } cond_t;

  // taken condition goes to jmp, otherwise to nxt; dispatch goes to the step decoded from the request
  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  jmp;
    upc_t  nxt;
  } ctrl_t;

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t cw;
    case (pc)
      U_WIPE:     cw = '{ACT_WIPE,       COND_WIPE_DONE, U_IDLE,     U_WIPE};
      U_IDLE:     cw = '{ACT_LATCH,      COND_IN_BEAT,   U_DECODE,   U_IDLE};
      U_DECODE:   cw = '{ACT_DECODE,     COND_DISPATCH,  U_RESULT,   U_RESULT};
      U_SCAN_RD:  cw = '{ACT_SCAN_START, COND_ALWAYS,    U_SCAN_CHK, U_SCAN_CHK};
      U_SCAN_CHK: cw = '{ACT_SCAN,       COND_SCAN_END,  U_RESULT,   U_SCAN_CHK};
      U_TEST_RD:  cw = '{ACT_READ_IDX,   COND_ALWAYS,    U_TEST_CAP, U_TEST_CAP};
      U_TEST_CAP: cw = '{ACT_TEST,       COND_ALWAYS,    U_RESULT,   U_RESULT};
      U_MARK_RD:  cw = '{ACT_READ_IDX,   COND_ALWAYS,    U_MARK_WR,  U_MARK_WR};
      U_MARK_WR:  cw = '{ACT_SET,        COND_ALWAYS,    U_RESULT,   U_RESULT};
      U_FREE_RD:  cw = '{ACT_READ_IDX,   COND_ALWAYS,    U_FREE_WR,  U_FREE_WR};
      U_FREE_WR:  cw = '{ACT_CLR,        COND_ALWAYS,    U_RESULT,   U_RESULT};
      U_RESULT:   cw = '{ACT_EMIT,       COND_OUT_FREE,  U_IDLE,     U_RESULT};
      default:    cw = '{ACT_NONE,       COND_ALWAYS,    U_IDLE,     U_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/fba_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fba_ram #(
  parameter int unsigned WIDTH = fba_pkg::WORD_BITS_DEF,
  parameter int unsigned DEPTH = fba_pkg::MAX_FRAMES_DEF / fba_pkg::WORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/frame_bitmap_allocator.sv -----
// first-fit physical frame bitmap allocator, microcoded control over one bitmap ram
//
// channel  dir  signals                              content
// s_axis   in   s_axis_tvalid/tready/tdata[55:0]     one request beat
// m_axis   out  m_axis_tvalid/tready/tdata[23:0]     one result beat per request
// cfg      in   cfg_wr_en, cfg_wr_data[12:0]         frame_count register
//
// allocate: scans the bitmap one word per cycle, up to ceil(MAX_FRAMES / WORD_BITS)
//   words, 128 by default, through the single ram read port
// free, mark, clear, test: read the word, then write or test its bit; skipped and
//   out of range requests go from decode to the result; after rst the whole ram
//   is wiped one word per cycle, s_axis_tready low; cfg writes are taken throughout
// a finished result waits in the output register while the next beat is accepted
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frame_bitmap_allocator #(
  parameter int unsigned MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // operation, entry_frame, kernel_page, writable_page, byte_address
  input  logic [fba_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // frame, present, writable, user, in_use, status
  output logic [fba_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_wr_en,
  input  logic [fba_pkg::CFG_W-1:0]       cfg_wr_data
);

  import fba_pkg::*;

  localparam int unsigned BW    = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIW   = (BW > 1) ? $clog2(BW) : 1;
  localparam int unsigned BIW   = $clog2(WORD_BITS);
  localparam int unsigned CW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned AFW   = ADDR_W - FRAME_SHIFT;
  localparam int unsigned KW    = (CW > AFW) ? CW : AFW;
  localparam int unsigned SH    = AFW + BIW;
  localparam int unsigned RW    = AFW + 2;
  localparam int unsigned RECIP = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned PW    = AFW + RW;

  logic [CFG_W-1:0]     frame_count;
  logic [KW-1:0]        cnt_lim;
  upc_t                 upc;
  upc_t                 upc_next;
  ctrl_t                ctrl;
  logic                 in_beat;
  logic                 out_free;
  logic                 taken;

  logic [2:0]           op;
  logic [FRAME_W-1:0]   entry_frame;
  logic                 kernel_page;
  logic                 writable_page;
  logic [AFW-1:0]       frame_idx;
  logic                 entry_range;
  logic                 idx_range;

  logic [AFW-1:0]       bit_idx;
  logic [WIW-1:0]       q;
  logic [WIW-1:0]       scan;
  logic [BIW-1:0]       bit_sel;
  logic [KW-1:0]        base;
  logic [KW-1:0]        left;
  logic [PW-1:0]        prod;
  logic [WIW-1:0]       q_calc;
  logic [AFW-1:0]       rem_full;

  logic [FRAME_W-1:0]   res_frame;
  logic                 res_present;
  logic                 res_writable;
  logic                 res_user;
  logic                 res_in_use;
  status_t              res_status;

  logic [FRAME_W-1:0]   out_frame;
  logic                 out_present;
  logic                 out_writable;
  logic                 out_user;
  logic                 out_in_use;
  status_t              out_status;

  upc_t                 disp_pc;
  status_t              disp_status;
  logic [FRAME_W-1:0]   disp_frame;

  logic [WORD_BITS-1:0] usable;
  logic                 scan_found;
  logic                 scan_last;
  logic                 scan_end;
  logic [BIW-1:0]       found_bit;
  logic [KW-1:0]        found_frame;
  logic [WORD_BITS-1:0] one_w;

  logic                 ram_we;
  logic [WIW-1:0]       ram_waddr;
  logic [WIW-1:0]       ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] rd_data;

  fba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BW)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign one_w    = WORD_BITS'(1);
  assign cnt_lim  = (KW'(frame_count) > KW'(MAX_FRAMES)) ? KW'(MAX_FRAMES) : KW'(frame_count);
  assign ctrl     = ucode(upc);
  assign s_axis_tready = (ctrl.act == ACT_LATCH);
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign entry_range = KW'(entry_frame) >= cnt_lim;
  assign idx_range   = KW'(frame_idx) >= cnt_lim;

  // frame whose bit is read or written, free works on the page entry frame
  assign bit_idx  = (op == 3'(OP_FREE)) ? AFW'(entry_frame) : frame_idx;

  // word and bit of a frame index, reciprocal multiply
  assign prod     = PW'(bit_idx) * PW'(RECIP);
  assign q_calc   = WIW'(prod >> SH);
  assign rem_full = bit_idx - (AFW'(q) * AFW'(WORD_BITS));

  // first free frame below the limit in the word under scan
  always_comb begin
    found_bit = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      usable[b] = !rd_data[b] && (KW'(b) < left);
    end
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (usable[b]) begin
        found_bit = BIW'(b);
      end
    end
  end

  assign scan_found  = |usable;
  assign scan_last   = left <= KW'(WORD_BITS);
  assign scan_end    = scan_found || scan_last;
  assign found_frame = base + KW'(found_bit);

  always_comb begin
    disp_pc     = U_RESULT;
    disp_status = ST_SKIP;
    disp_frame  = '0;
    case (op_t'(op))
      OP_ALLOC: begin
        if (entry_frame != '0) begin
          disp_frame = entry_frame;
        end else begin
          disp_pc     = U_SCAN_RD;
          disp_status = ST_FULL;
        end
      end
      OP_FREE: begin
        if (entry_frame == '0) begin
          disp_status = ST_SKIP;
        end else if (entry_range) begin
          disp_status = ST_RANGE;
        end else begin
          disp_status = ST_DONE;
          disp_pc     = U_FREE_RD;
        end
      end
      OP_TEST: begin
        disp_frame  = frame_idx[FRAME_W-1:0];
        disp_status = idx_range ? ST_RANGE : ST_DONE;
        disp_pc     = idx_range ? U_RESULT : U_TEST_RD;
      end
      OP_MARK: begin
        disp_frame  = frame_idx[FRAME_W-1:0];
        disp_status = idx_range ? ST_RANGE : ST_DONE;
        disp_pc     = idx_range ? U_RESULT : U_MARK_RD;
      end
      OP_CLEAR: begin
        disp_frame  = frame_idx[FRAME_W-1:0];
        disp_status = idx_range ? ST_RANGE : ST_DONE;
        disp_pc     = idx_range ? U_RESULT : U_FREE_RD;
      end
      default: begin
        disp_status = ST_SKIP;
      end
    endcase
  end

  // next step
  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_WIPE_DONE: taken = (scan == WIW'(BW - 1));
      COND_IN_BEAT:   taken = in_beat;
      COND_SCAN_END:  taken = scan_end;
      COND_OUT_FREE:  taken = out_free;
      default:        taken = 1'b1;
    endcase
    if (ctrl.cond == COND_DISPATCH) begin
      upc_next = disp_pc;
    end else if (taken) begin
      upc_next = ctrl.jmp;
    end else begin
      upc_next = ctrl.nxt;
    end
  end

  // bitmap ram ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan;
    ram_wdata = rd_data;
    ram_raddr = scan;
    case (ctrl.act)
      ACT_WIPE: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ACT_SCAN_START: begin
        ram_raddr = '0;
      end
      ACT_SCAN: begin
        ram_we    = scan_found;
        ram_wdata = rd_data | (one_w << found_bit);
        ram_raddr = scan_end ? scan : scan + WIW'(1);
      end
      ACT_READ_IDX: begin
        ram_raddr = q;
      end
      ACT_SET: begin
        ram_we    = 1'b1;
        ram_waddr = q;
        ram_wdata = rd_data | (one_w << bit_sel);
      end
      ACT_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = q;
        ram_wdata = rd_data & ~(one_w << bit_sel);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc           <= U_WIPE;
      scan          <= '0;
      frame_count   <= CFG_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (cfg_wr_en) begin
        frame_count <= cfg_wr_data;
      end
      case (ctrl.act)
        ACT_WIPE:       scan <= scan + WIW'(1);
        ACT_SCAN_START: scan <= '0;
        ACT_SCAN: begin
          if (!scan_end) begin
            scan <= scan + WIW'(1);
          end
        end
        default: scan <= scan;
      endcase
      if (ctrl.act == ACT_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.act)
      ACT_LATCH: begin
        if (in_beat) begin
          op            <= s_axis_tdata[2:0];
          entry_frame   <= s_axis_tdata[14:3];
          kernel_page   <= s_axis_tdata[15];
          writable_page <= s_axis_tdata[16];
          frame_idx     <= s_axis_tdata[48:17+FRAME_SHIFT];
        end
      end
      ACT_DECODE: begin
        q            <= q_calc;
        res_frame    <= disp_frame;
        res_status   <= disp_status;
        res_present  <= 1'b0;
        res_writable <= 1'b0;
        res_user     <= 1'b0;
        res_in_use   <= 1'b0;
      end
      ACT_SCAN_START: begin
        base <= '0;
        left <= cnt_lim;
      end
      ACT_SCAN: begin
        if (!scan_end) begin
          base <= base + KW'(WORD_BITS);
          left <= left - KW'(WORD_BITS);
        end
        if (scan_found) begin
          res_frame    <= found_frame[FRAME_W-1:0];
          res_present  <= 1'b1;
          res_writable <= writable_page;
          res_user     <= !kernel_page;
          res_status   <= ST_DONE;
        end
      end
      ACT_READ_IDX: begin
        bit_sel <= rem_full[BIW-1:0];
      end
      ACT_TEST: begin
        res_in_use <= rd_data[bit_sel];
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_frame    <= res_frame;
          out_present  <= res_present;
          out_writable <= res_writable;
          out_user     <= res_user;
          out_in_use   <= res_in_use;
          out_status   <= res_status;
        end
      end
      default: begin
        bit_sel <= bit_sel;
      end
    endcase
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_status, out_in_use,
                         out_user, out_writable, out_present, out_frame};

  `FBA_ASSERT(a_result_held, (upc == U_RESULT && !out_free) |=> (upc == U_RESULT), "pending result dropped")
  `FBA_ASSERT_IMP(a_found_in_range, upc == U_SCAN_CHK && scan_found, found_frame < cnt_lim, "allocated frame beyond frame count")
  `FBA_ASSERT_IMP(a_in_use_status, m_axis_tvalid && out_in_use, out_status == ST_DONE && !out_present, "in_use set on a non test result")

endmodule

// ----- tb/tb_frame_bitmap_allocator.sv -----
// self-checking testbench for the first-fit frame bitmap allocator
`timescale 1ns / 1ps
module tb_frame_bitmap_allocator;
  import fba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned PRINT_LIMIT = 100;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'(OP_CLEAR) + 3'd1;
  localparam logic [2:0] OP_UNUSED_LAST = 3'b111;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] entry_frame;
    logic        kernel_page;
    logic        writable_page;
    logic [31:0] byte_address;
  } frame_request_t;

  typedef struct packed {
    logic [11:0] frame;
    logic        present;
    logic        writable;
    logic        user;
    logic        in_use;
    status_t     status;
  } frame_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  // predictor state
  bit frame_used [MAX_FRAMES_DEF];
  logic [CFG_W-1:0] frame_count_cfg = CFG_RESET;
  frame_reply_t pending_replies[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit send_gaps = 1'b0;
  bit stalls_on = 1'b0;
  int unsigned hold_request = 0;

  frame_bitmap_allocator dut (
    .clk          (clk),
    .rst          (rst),
    // operation, entry_frame, kernel_page, writable_page, byte_address
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    // frame, present, writable, user, in_use, status
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned usable_frames();
    return (frame_count_cfg > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(frame_count_cfg);
  endfunction

  // applies one request to the predicted bitmap and returns the reply it gives
  function automatic frame_reply_t apply_request(input frame_request_t req);
    frame_reply_t res;
    int unsigned lim;
    int unsigned f;
    res = '0;
    lim = usable_frames();
    case (req.operation)
      OP_ALLOC: begin
        if (req.entry_frame != 0) begin
          res.frame = req.entry_frame;
          res.status = ST_SKIP;
        end else begin
          f = 0;
          while (f < lim && frame_used[f]) f++;
          if (f >= lim) begin
            res.status = ST_FULL;
          end else begin
            frame_used[f] = 1'b1;
            res.frame = f[11:0];
            res.present = 1'b1;
            res.writable = req.writable_page;
            res.user = !req.kernel_page;
            res.status = ST_DONE;
          end
        end
      end
      OP_FREE: begin
        if (req.entry_frame == 0) begin
          res.status = ST_SKIP;
        end else if (req.entry_frame >= lim) begin
          res.status = ST_RANGE;
        end else begin
          frame_used[req.entry_frame] = 1'b0;
          res.status = ST_DONE;
        end
      end
      OP_TEST, OP_MARK, OP_CLEAR: begin
        f = req.byte_address >> FRAME_SHIFT;
        res.frame = f[11:0];
        if (f >= lim) begin
          res.status = ST_RANGE;
        end else begin
          if (req.operation == OP_TEST) res.in_use = frame_used[f];
          else frame_used[f] = (req.operation == OP_MARK);
          res.status = ST_DONE;
        end
      end
      default: res.status = ST_SKIP;
    endcase
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < PRINT_LIMIT)
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_reply(input logic [OUT_TDATA_W-1:0] beat);
    frame_reply_t want;
    if (pending_replies.size() == 0) begin
      report_mismatch("result beat with nothing pending", beat, 0);
      return;
    end
    want = pending_replies.pop_front();
    if (beat[11:0] != want.frame) report_mismatch("frame", beat[11:0], want.frame);
    if (beat[12] != want.present) report_mismatch("present", beat[12], want.present);
    if (beat[13] != want.writable) report_mismatch("writable", beat[13], want.writable);
    if (beat[14] != want.user) report_mismatch("user", beat[14], want.user);
    if (beat[15] != want.in_use) report_mismatch("in_use", beat[15], want.in_use);
    if (beat[17:16] != want.status) report_mismatch("status", beat[17:16], want.status);
  endtask

  // result side: checks each beat, drives tready with held and random stalls
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) check_reply(m_axis_tdata);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (stalls_on) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_request(input logic [2:0] op, input logic [11:0] entry,
                              input logic kern, input logic wr, input logic [31:0] addr);
    frame_request_t req;
    int unsigned gap;
    req = '{op, entry, kern, wr, addr};
    s_axis_tdata <= {7'd0, addr, wr, kern, entry, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_replies.push_back(apply_request(req));
    if (send_gaps) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_count_cfg = value;
  endtask

  function automatic logic [19:0] pick_frame_index();
    int unsigned lim = usable_frames();
    if (lim == 0 || $urandom_range(0, 9) < 2) return 20'($urandom_range(0, 4095));
    return 20'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_random_request();
    logic [2:0] op;
    logic [11:0] entry;
    logic [31:0] addr;
    int unsigned r;
    r = $urandom_range(0, 99);
    entry = '0;
    addr = $urandom();
    op = OP_ALLOC;
    if (r < 38) begin
      op = OP_ALLOC;
    end else if (r < 43) begin
      op = OP_ALLOC;
      entry = 12'($urandom_range(1, 4095));
    end else if (r < 68) begin
      op = OP_FREE;
      case ($urandom_range(0, 9))
        0: entry = '0;
        1: entry = 12'($urandom());
        default: entry = 12'(pick_frame_index());
      endcase
    end else if (r < 95) begin
      case ($urandom_range(0, 2))
        0: op = OP_TEST;
        1: op = OP_MARK;
        default: op = OP_CLEAR;
      endcase
      if ($urandom_range(0, 9) != 0) addr = {pick_frame_index(), 12'($urandom())};
    end else begin
      op = OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
    end
    send_request(op, entry, 1'($urandom()), 1'($urandom()), addr);
  endtask

  task automatic test_operations_at_reset_count();
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1, 32'h0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 12'hFFF, 1'b1, 1'b1, 32'h0);
    send_request(OP_ALLOC, 12'd1, 1'b0, 1'b0, 32'h0);
    send_request(OP_FREE, 12'd0, 1'b1, 1'b1, 32'h0);
    send_request(OP_FREE, 12'd1, 1'b0, 1'b0, 32'h0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1, 32'h0);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h0000_0000);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h0000_2FFF);
    send_request(OP_MARK, 12'hFFF, 1'b1, 1'b1, 32'h0000_2000);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h0000_2ABC);
    send_request(OP_CLEAR, 12'd0, 1'b0, 1'b0, 32'h0000_2000);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h0000_2000);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    send_request(OP_MARK, 12'd0, 1'b0, 1'b0, 32'h00FF_F000);
    send_request(OP_FREE, 12'hFFF, 1'b0, 1'b0, 32'h0);
    send_request(OP_CLEAR, 12'd0, 1'b0, 1'b0, 32'h0100_0000);
    send_request(OP_UNUSED_FIRST, 12'hFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_request(OP_UNUSED_FIRST + 3'd1, 12'd0, 1'b0, 1'b0, 32'h0);
    send_request(OP_UNUSED_LAST, 12'h5A5, 1'b1, 1'b0, 32'hA5A5_5A5A);
    wait_idle();
  endtask

  task automatic test_frame_count_extremes();
    write_frame_count('0);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b1, 32'h0);
    send_request(OP_FREE, 12'd5, 1'b0, 1'b0, 32'h0);
    send_request(OP_FREE, 12'd0, 1'b0, 1'b0, 32'h0);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h0);
    wait_idle();
    write_frame_count(13'd3);
    send_request(OP_ALLOC, 12'd0, 1'b0, 1'b0, 32'h0);
    send_request(OP_ALLOC, 12'd0, 1'b1, 1'b1, 32'h0);
    send_request(OP_FREE, 12'd3, 1'b0, 1'b0, 32'h0);
    send_request(OP_FREE, 12'd2, 1'b0, 1'b0, 32'h0);
    wait_idle();
    // above the bitmap size the count saturates
    write_frame_count('1);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h0100_0000);
    send_request(OP_MARK, 12'd0, 1'b0, 1'b0, 32'h00FF_FFFF);
    send_request(OP_TEST, 12'd0, 1'b0, 1'b0, 32'h00FF_F123);
    send_request(OP_FREE, 12'hFFF, 1'b0, 1'b0, 32'h0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] counts [8];
    counts = '{13'd40, 13'd4096, 13'd1, 13'h1FFF, 13'd200, 13'd33, 13'd0, 13'd4095};
    for (int i = 0; i < 8; i++) begin
      write_frame_count(counts[i]);
      send_gaps = (i % 3 != 2);
      stalls_on = (i % 3 != 1);
      repeat (250) send_random_request();
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    write_frame_count(13'd64);
    send_gaps = 1'b0;
    stalls_on = 1'b0;
    hold_request = 300;
    repeat (30) send_random_request();
    wait_idle();
    send_gaps = 1'b1;
    stalls_on = 1'b1;
    hold_request = 200;
    repeat (30) send_random_request();
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_operations_at_reset_count();
    test_frame_count_extremes();
    test_random_traffic();
    test_output_backpressure();
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/frame_bitmap_allocator.sv
tb/tb_frame_bitmap_allocator.sv
